FILE: src/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg
// shared types and constants of the serial tone command block
// ----------------------------------------------------------------------------
package stc_pkg;

    localparam int LINE_BYTES = 8;
    localparam int CNT_W      = $clog2(LINE_BYTES);

    localparam int FREQ_W  = 16;
    localparam int SCALE_W = 20;
    localparam int LIMIT_W = 8;
    localparam int CMP_W   = 8;
    localparam int ACC_W   = 17;
    localparam int CFG_W   = SCALE_W;
    localparam int IDX_W   = 2;

    localparam int DIV_STEPS = SCALE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [ACC_W-1:0] ACCUM_SAT = ACC_W'(65536);

    localparam logic [FREQ_W-1:0]  MIN_FREQ_RST   = FREQ_W'(262);
    localparam logic [FREQ_W-1:0]  MAX_FREQ_RST   = FREQ_W'(2000);
    localparam logic [SCALE_W-1:0] TONE_SCALE_RST = SCALE_W'(62500);
    localparam logic [LIMIT_W-1:0] TICK_LIMIT_RST = LIMIT_W'(10);

    localparam logic [IDX_W-1:0] REG_MIN_FREQ   = 2'd0;
    localparam logic [IDX_W-1:0] REG_MAX_FREQ   = 2'd1;
    localparam logic [IDX_W-1:0] REG_TONE_SCALE = 2'd2;
    localparam logic [IDX_W-1:0] REG_TICK_LIMIT = 2'd3;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [CMP_W-1:0] CMP_MAX = '1;

    typedef struct packed {
        logic [ACC_W-1:0] accum;
        logic             negative;
        logic             full;
        logic             is_cr;
    } t_line;

    typedef struct packed {
        logic               start;
        logic [SCALE_W-1:0] dividend;
        logic [FREQ_W-1:0]  divisor;
    } t_div_req;

endpackage

FILE: src/stc_in_if.sv
// ----------------------------------------------------------------------------
// stc_in_if
// input channel: action flag and received byte with valid/ready
// ----------------------------------------------------------------------------
interface stc_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

FILE: src/stc_out_if.sv
// ----------------------------------------------------------------------------
// stc_out_if
// result channel: compare value and status flags with valid/ready
// ----------------------------------------------------------------------------
interface stc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] compare_value;
    logic       command_done;
    logic       line_dropped;

    modport source (output valid, output compare_value, output command_done,
                    output line_dropped, input ready);
    modport sink   (input valid, input compare_value, input command_done,
                    input line_dropped, output ready);
endinterface

FILE: src/serial_tone_command.sv
// ----------------------------------------------------------------------------
// serial_tone_command
// serial frequency commands to tone compare value, with duration ticks
// ----------------------------------------------------------------------------
// results: a tick, a byte, a dropped line or a zero frequency gives a registered
//   result word; a command that divides passes through the 20-step divider first
// throughput: one word per cycle while the result channel is free; no new word
//   is taken while the shared bit-serial divider works on a dividing command
// reset: synchronous active low, clears parser, tone state and the result valid
//   flag and restores the register defaults
// ----------------------------------------------------------------------------
module serial_tone_command
    import stc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    stc_in_if.sink           i_in,
    stc_out_if.source        o_out,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [FREQ_W-1:0]  r_min_freq;
    logic [FREQ_W-1:0]  r_max_freq;
    logic [SCALE_W-1:0] r_tone_scale;
    logic [LIMIT_W-1:0] r_tick_limit;

    logic [1:0]         r_state, n_state;
    logic               r_armed, n_armed;
    logic [LIMIT_W-1:0] r_tick_count, n_tick_count;
    logic [CMP_W-1:0]   r_tone, n_tone;
    logic               r_pend_done, n_pend_done;
    logic               r_pend_drop, n_pend_drop;
    logic               r_out_valid, n_out_valid;
    logic [CMP_W-1:0]   r_out_cmp, n_out_cmp;
    logic               r_out_done, n_out_done;
    logic               r_out_drop, n_out_drop;

    logic               acc;
    logic               out_free;
    logic               res_load;
    logic               res_done;
    logic               res_drop;
    t_line              line;
    t_div_req           div_req;
    logic               div_done;
    logic [SCALE_W-1:0] quotient;
    logic [FREQ_W-1:0]  freq;
    logic [CMP_W-1:0]   sat_cmp;

    assign i_in.ready = (r_state == ST_IDLE);
    assign acc        = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;

    stc_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_en (acc && (i_in.action == ACT_BYTE)),
        .i_byte    (i_in.rx_byte),
        .o_line    (line)
    );

    stc_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // clamp: a negative value goes to the min bound, then the max bound is tested before the min bound
    always_comb begin
        if (line.negative && line.accum != '0) begin
            freq = r_min_freq;
        end else if (line.accum > {1'b0, r_max_freq}) begin
            freq = r_max_freq;
        end else if (line.accum < {1'b0, r_min_freq}) begin
            freq = r_min_freq;
        end else begin
            freq = line.accum[FREQ_W-1:0];
        end
    end

    always_comb begin
        if (quotient == '0) begin
            sat_cmp = '0;
        end else if (quotient > SCALE_W'(256)) begin
            sat_cmp = CMP_MAX;
        end else begin
            sat_cmp = CMP_W'(quotient - 1'b1);
        end
    end

    always_comb begin
        n_state      = r_state;
        n_armed      = r_armed;
        n_tick_count = r_tick_count;
        n_tone       = r_tone;
        n_pend_done  = r_pend_done;
        n_pend_drop  = r_pend_drop;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_cmp    = r_out_cmp;
        n_out_done   = r_out_done;
        n_out_drop   = r_out_drop;
        res_load     = 1'b0;
        res_done     = 1'b0;
        res_drop     = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = r_tone_scale;
        div_req.divisor  = freq;

        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    if (i_in.action == ACT_TICK) begin
                        if (r_armed && r_tick_count <= r_tick_limit) begin
                            n_tick_count = r_tick_count + 1'b1;
                        end else begin
                            n_tone       = '0;
                            n_tick_count = '0;
                        end
                        res_load = 1'b1;
                    end else if (line.full) begin
                        res_load = 1'b1;
                        res_drop = 1'b1;
                    end else if (line.is_cr) begin
                        n_armed = 1'b1;
                        if (freq == '0) begin
                            n_tone   = CMP_MAX;
                            res_load = 1'b1;
                            res_done = 1'b1;
                        end else begin
                            div_req.start = 1'b1;
                            n_state       = ST_DIV;
                        end
                    end else begin
                        res_load = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_tone   = sat_cmp;
                    res_load = 1'b1;
                    res_done = 1'b1;
                end
            end
            ST_WAIT: begin
                res_load = 1'b1;
                res_done = r_pend_done;
                res_drop = r_pend_drop;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (res_load) begin
            if (out_free) begin
                n_out_valid = 1'b1;
                n_out_cmp   = n_tone;
                n_out_done  = res_done;
                n_out_drop  = res_drop;
                n_state     = ST_IDLE;
            end else begin
                n_pend_done = res_done;
                n_pend_drop = res_drop;
                n_state     = ST_WAIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_freq   <= MIN_FREQ_RST;
            r_max_freq   <= MAX_FREQ_RST;
            r_tone_scale <= TONE_SCALE_RST;
            r_tick_limit <= TICK_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MIN_FREQ:   r_min_freq   <= i_cfg_data[FREQ_W-1:0];
                REG_MAX_FREQ:   r_max_freq   <= i_cfg_data[FREQ_W-1:0];
                REG_TONE_SCALE: r_tone_scale <= i_cfg_data[SCALE_W-1:0];
                REG_TICK_LIMIT: r_tick_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_armed      <= 1'b0;
            r_tick_count <= '0;
            r_tone       <= '0;
            r_pend_done  <= 1'b0;
            r_pend_drop  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_armed      <= n_armed;
            r_tick_count <= n_tick_count;
            r_tone       <= n_tone;
            r_pend_done  <= n_pend_done;
            r_pend_drop  <= n_pend_drop;
            r_out_valid  <= n_out_valid;
        end
        r_out_cmp  <= n_out_cmp;
        r_out_done <= n_out_done;
        r_out_drop <= n_out_drop;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.compare_value = r_out_cmp;
    assign o_out.command_done  = r_out_done;
    assign o_out.line_dropped  = r_out_drop;

`ifndef SYNTHESIS
    a_tone_only_on_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!acc && !div_done) |=> $stable(r_tone))
        else $error("tone compare changed without a word or divider result");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_done && r_out_drop))
        else $error("command done and line dropped in one result word");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");

    a_start_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |=> (r_state == ST_DIV) && !i_in.ready)
        else $error("divider start did not enter the divide state");
`endif

endmodule

FILE: src/stc_divider.sv
// ----------------------------------------------------------------------------
// stc_divider
// restoring radix-2 divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module stc_divider
    import stc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_div_req           i_req,
    output logic               o_done,
    output logic [SCALE_W-1:0] o_quotient
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [FREQ_W-1:0]    r_rem, n_rem;
    logic [SCALE_W-1:0]   r_quo, n_quo;
    logic [FREQ_W-1:0]    r_div, n_div;
    logic [FREQ_W:0]      shifted;
    logic [FREQ_W:0]      diff;

    always_comb begin
        shifted = {r_rem, r_quo[SCALE_W-1]};
        diff    = shifted - {1'b0, r_div};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_div   = r_div;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_div  = i_req.divisor;
        end else if (r_busy) begin
            if (!diff[FREQ_W]) begin
                n_rem = diff[FREQ_W-1:0];
                n_quo = {r_quo[SCALE_W-2:0], 1'b1};
            end else begin
                n_rem = shifted[FREQ_W-1:0];
                n_quo = {r_quo[SCALE_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: src/stc_parser.sv
// ----------------------------------------------------------------------------
// stc_parser
// line buffer count and decimal number parser, one byte per word
// ----------------------------------------------------------------------------
module stc_parser
    import stc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_byte_en,
    input  logic [7:0] i_byte,
    output t_line      o_line
);

    localparam logic [1:0] PH_LEAD  = 2'd0;
    localparam logic [1:0] PH_SIGN  = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;
    localparam logic [1:0] PH_STOP  = 2'd3;

    logic [CNT_W-1:0] r_char_count, n_char_count;
    logic [1:0]       r_phase, n_phase;
    logic             r_negative, n_negative;
    logic [ACC_W-1:0] r_accum, n_accum;

    logic             full;
    logic             is_cr;
    logic             digit;
    logic             blank;
    logic [ACC_W+3:0] prod;

    assign full  = (r_char_count == CNT_W'(LINE_BYTES - 1));
    assign is_cr = (i_byte == CH_CR);
    assign digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);

    always_comb begin
        unique case (i_byte) inside
            CH_SP, CH_HT, CH_LF, CH_VT, CH_FF: blank = 1'b1;
            default:                           blank = 1'b0;
        endcase
    end

    // accum * 10 + digit
    assign prod = ((ACC_W+4)'(r_accum) << 3) + ((ACC_W+4)'(r_accum) << 1)
                + (ACC_W+4)'(i_byte[3:0]);

    always_comb begin
        n_char_count = r_char_count;
        n_phase      = r_phase;
        n_negative   = r_negative;
        n_accum      = r_accum;
        if (i_byte_en) begin
            if (full || is_cr) begin
                n_char_count = '0;
                n_phase      = PH_LEAD;
                n_negative   = 1'b0;
                n_accum      = '0;
            end else begin
                n_char_count = r_char_count + 1'b1;
                if (r_phase != PH_STOP) begin
                    if (digit) begin
                        n_accum = (prod > (ACC_W+4)'(ACCUM_SAT)) ? ACCUM_SAT
                                                                 : prod[ACC_W-1:0];
                        n_phase = PH_DIGIT;
                    end else if (r_phase == PH_LEAD && blank) begin
                        n_phase = PH_LEAD;
                    end else if (r_phase == PH_LEAD &&
                                 (i_byte == CH_PLUS || i_byte == CH_MINUS)) begin
                        n_negative = (i_byte == CH_MINUS);
                        n_phase    = PH_SIGN;
                    end else begin
                        n_phase = PH_STOP;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_count <= '0;
            r_phase      <= PH_LEAD;
            r_negative   <= 1'b0;
            r_accum      <= '0;
        end else begin
            r_char_count <= n_char_count;
            r_phase      <= n_phase;
            r_negative   <= n_negative;
            r_accum      <= n_accum;
        end
    end

    assign o_line.accum    = r_accum;
    assign o_line.negative = r_negative;
    assign o_line.full     = full;
    assign o_line.is_cr    = is_cr;

endmodule
